[hw/rtl/l2tpd_pkg.sv]
// ----------------------------------------------------------------------------
// L2TP decapsulator package
// Shared widths, header flag positions, verdict codes and stage types.
// ----------------------------------------------------------------------------
package l2tpd_pkg;

	localparam int MAX_IFACES_DEF = 256;

	localparam int POS_W   = 17;
	localparam int PKTS_W  = 32;
	localparam int BYTES_W = 48;
	localparam int WORD_W  = PKTS_W + BYTES_W;

	localparam logic [POS_W-1:0] POS_MAX  = 17'h1FFFF;
	localparam logic [3:0]       HDR_BASE = 4'd6;
	localparam logic [3:0]       VER_RST  = 4'd2;

	localparam int FLAG_T = 7;
	localparam int FLAG_L = 6;
	localparam int FLAG_S = 3;
	localparam int FLAG_O = 1;

	localparam logic [1:0] VERDICT_PASS = 2'd0;
	localparam logic [1:0] VERDICT_CTRL = 2'd1;
	localparam logic [1:0] VERDICT_FAIL = 2'd2;

	typedef struct packed {
		logic [1:0]       verdict;
		logic [POS_W-1:0] strip;
	} parse_res_t;

	typedef struct packed {
		logic [PKTS_W-1:0]  pkts;
		logic [BYTES_W-1:0] bytes;
	} cnt_word_t;

endpackage

[hw/rtl/l2tpd_ifs.sv]
// ----------------------------------------------------------------------------
// L2TP decapsulator channels
// Valid/ready channels for packet bytes in and parse results out.
// ----------------------------------------------------------------------------
interface l2tpd_pkt_if;
	logic       valid;
	logic       ready;
	logic [7:0] packet_byte;
	logic       first_byte;
	logic       last_byte;
	logic [7:0] rx_interface;

	modport source (output valid, packet_byte, first_byte, last_byte, rx_interface,
		input ready);
	modport sink (input valid, packet_byte, first_byte, last_byte, rx_interface,
		output ready);
endinterface

interface l2tpd_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  verdict;
	logic [16:0] strip_length;
	logic [7:0]  out_interface;
	logic [31:0] packet_count;
	logic [47:0] byte_total;

	modport source (output valid, verdict, strip_length, out_interface, packet_count,
		byte_total, input ready);
	modport sink (input valid, verdict, strip_length, out_interface, packet_count,
		byte_total, output ready);
endinterface

[hw/rtl/l2tpd_parse.sv]
// ----------------------------------------------------------------------------
// L2TP header parser
// Tracks byte position and header fields; gives the verdict at each byte.
// ----------------------------------------------------------------------------
module l2tpd_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc,
	input  logic [7:0]          packet_byte,
	input  logic                first_byte,
	input  logic                last_byte,
	input  logic [3:0]          exp_ver,
	output l2tpd_pkg::parse_res_t prs
);
	import l2tpd_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       flg_q;
	logic [3:0]       ver_q;
	logic [15:0]      off_q;

	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] len;
	logic [POS_W-1:0] strip_full;
	logic [7:0]       flg;
	logic [3:0]       ver;
	logic [3:0]       opos;
	logic [15:0]      off_nx;

	always_comb begin
		pos  = first_byte ? '0 : pos_q;
		flg  = (pos == '0) ? packet_byte : flg_q;
		ver  = (pos == POS_W'(1)) ? packet_byte[3:0] : ver_q;
		opos = HDR_BASE + (flg[FLAG_L] ? 4'd2 : 4'd0) + (flg[FLAG_S] ? 4'd4 : 4'd0);
		off_nx = off_q;
		if (pos == POS_W'(opos)) begin
			off_nx[15:8] = packet_byte;
		end
		if (pos == POS_W'(opos) + POS_W'(1)) begin
			off_nx[7:0] = packet_byte;
		end
		len = (pos != POS_MAX) ? pos + POS_W'(1) : pos;
		strip_full = POS_W'(opos) + (flg[FLAG_O] ? (POS_W'(off_nx) + POS_W'(2)) : '0);

		prs.strip = '0;
		if (len < POS_W'(HDR_BASE) || ver != exp_ver) begin
			prs.verdict = VERDICT_FAIL;
		end else if (flg[FLAG_T]) begin
			prs.verdict = VERDICT_CTRL;
		end else if (len < strip_full) begin
			prs.verdict = VERDICT_FAIL;
		end else begin
			prs.verdict = VERDICT_PASS;
			prs.strip   = strip_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			flg_q <= '0;
			ver_q <= '0;
			off_q <= '0;
		end else if (acc) begin
			pos_q <= last_byte ? '0 : len;
			flg_q <= flg;
			ver_q <= ver;
			off_q <= off_nx;
		end
	end

endmodule

[hw/rtl/l2tpd_count.sv]
// ----------------------------------------------------------------------------
// L2TP per-interface counters
// Counter memory with clearing pass, update stage and result register.
// ----------------------------------------------------------------------------
module l2tpd_count #(
	parameter int MAX_IFACES = l2tpd_pkg::MAX_IFACES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                ld,
	input  l2tpd_pkg::parse_res_t               prs,
	input  logic [7:0]                          iface,
	output logic                                rdy,
	output logic                                out_vld,
	input  logic                                out_rdy,
	output logic [1:0]                          out_verdict,
	output logic [l2tpd_pkg::POS_W-1:0]         out_strip,
	output logic [7:0]                          out_iface,
	output logic [l2tpd_pkg::PKTS_W-1:0]        out_pkts,
	output logic [l2tpd_pkg::BYTES_W-1:0]       out_bytes
);
	import l2tpd_pkg::*;

	localparam int IW = (MAX_IFACES > 1) ? $clog2(MAX_IFACES) : 1;

	cnt_word_t mem_q [MAX_IFACES];

	logic          clr_busy_q;
	logic [IW-1:0] clr_idx_q;

	logic             vld_s1;
	logic [1:0]       verdict_s1;
	logic [POS_W-1:0] strip_s1;
	logic [7:0]       iface_s1;
	logic [IW-1:0]    addr_s1;
	logic             upd_s1;
	logic             hit_s1;
	cnt_word_t        rd_s1;
	cnt_word_t        byp_q;

	logic [IW+7:0] iface_ext;
	logic [IW-1:0] rd_addr;
	logic          in_rng;
	logic          adv;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	cnt_word_t     wr_data;
	cnt_word_t     base;
	cnt_word_t     upd_word;
	logic          s1_wr;

	assign iface_ext = {IW'(0), iface};
	assign rd_addr   = iface_ext[IW-1:0];
	assign in_rng    = (32'(iface) < MAX_IFACES);

	assign adv = !out_vld || out_rdy;
	assign rdy = !clr_busy_q && (!vld_s1 || adv);
	assign s1_wr = vld_s1 && adv && upd_s1;

	always_comb begin
		base = hit_s1 ? byp_q : rd_s1;
		upd_word.pkts  = base.pkts + PKTS_W'(1);
		upd_word.bytes = base.bytes + BYTES_W'(strip_s1);
		if (clr_busy_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_idx_q;
			wr_data = '0;
		end else begin
			wr_en   = s1_wr;
			wr_addr = addr_s1;
			wr_data = upd_word;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ld) begin
			rd_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + IW'(1);
			if (clr_idx_q == IW'(MAX_IFACES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ld) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			verdict_s1 <= prs.verdict;
			strip_s1   <= prs.strip;
			iface_s1   <= iface;
			addr_s1    <= rd_addr;
			upd_s1     <= (prs.verdict == VERDICT_PASS) && in_rng;
			hit_s1     <= s1_wr && (addr_s1 == rd_addr);
		end
		if (s1_wr) begin
			byp_q <= upd_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (adv) begin
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			out_verdict <= verdict_s1;
			out_strip   <= strip_s1;
			out_iface   <= iface_s1;
			out_pkts    <= upd_s1 ? upd_word.pkts : '0;
			out_bytes   <= upd_s1 ? upd_word.bytes : '0;
		end
	end

endmodule

[hw/rtl/l2tp_header_decapsulator_top.sv]
// ----------------------------------------------------------------------------
// L2TPv2 header decapsulator
// Parses L2TPv2 headers byte by byte and keeps per-interface detunnel counters.
// ----------------------------------------------------------------------------
//  channel | dir | items                       | handshake
//  pkt     | in  | one packet byte with marks  | valid/ready
//  res     | out | verdict, strip, counters    | valid/ready
//  cfg     | in  | expected version nibble     | cfg_we, no wait
//
//  One byte is taken per cycle unless clearing runs or a stalled result holds the
//  update stage; the result of a last byte passes the counter memory read and
//  update stage, then the result register. After reset a clearing pass zeroes
//  the counter memory, with pkt.ready low throughout.
//  A stalled result holds; bytes are still taken while the update stage is free.
// ----------------------------------------------------------------------------
module l2tp_header_decapsulator_top #(
	parameter int MAX_IFACES = l2tpd_pkg::MAX_IFACES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [3:0]     cfg_wdata,
	l2tpd_pkt_if.sink      pkt,
	l2tpd_res_if.source    res
);
	import l2tpd_pkg::*;

	logic [3:0] ver_cfg_q;
	logic       acc;
	logic       rdy;
	parse_res_t prs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_cfg_q <= VER_RST;
		end else if (cfg_we) begin
			ver_cfg_q <= cfg_wdata;
		end
	end

	assign pkt.ready = rdy;
	assign acc       = pkt.valid && rdy;

	l2tpd_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.packet_byte (pkt.packet_byte),
		.first_byte  (pkt.first_byte),
		.last_byte   (pkt.last_byte),
		.exp_ver     (ver_cfg_q),
		.prs         (prs)
	);

	l2tpd_count #(
		.MAX_IFACES (MAX_IFACES)
	) u_count (
		.clk         (clk),
		.arst_n      (arst_n),
		.ld          (acc && pkt.last_byte),
		.prs         (prs),
		.iface       (pkt.rx_interface),
		.rdy         (rdy),
		.out_vld     (res.valid),
		.out_rdy     (res.ready),
		.out_verdict (res.verdict),
		.out_strip   (res.strip_length),
		.out_iface   (res.out_interface),
		.out_pkts    (res.packet_count),
		.out_bytes   (res.byte_total)
	);

endmodule

[hw/rtl/l2tpd_chk.sv]
// ----------------------------------------------------------------------------
// L2TP decapsulator checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module l2tpd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  verdict,
	input logic [16:0] strip_length,
	input logic [31:0] packet_count,
	input logic [47:0] byte_total
);
	import l2tpd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(verdict)
			&& $stable(strip_length) && $stable(packet_count) && $stable(byte_total))
		else $error("result changed while stalled");

	a_strip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && verdict != VERDICT_PASS |-> strip_length == '0)
		else $error("strip length on a non-detunneled item");

	a_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && verdict != VERDICT_PASS |-> packet_count == '0 && byte_total == '0)
		else $error("counters reported on a non-detunneled item");

	a_strip_rng: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && verdict == VERDICT_PASS |-> strip_length >= 17'd6
			&& strip_length <= 17'd65549)
		else $error("strip length out of range");

endmodule

bind l2tp_header_decapsulator_top l2tpd_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.verdict      (res.verdict),
	.strip_length (res.strip_length),
	.packet_count (res.packet_count),
	.byte_total   (res.byte_total)
);

[tb/l2tp_header_decapsulator_top_test.sv]
// ----------------------------------------------------------------------------
// L2TPv2 header decapsulator testbench
// Streams packets byte by byte into the decapsulator and checks every result
// against an in-bench header parser and per-interface counter tracker.
// Covers directed corner packets, random traffic at several version settings,
// result back-pressure and one long packet with a wide offset field.
// ----------------------------------------------------------------------------
module l2tp_header_decapsulator_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import l2tpd_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int LONG_LEN    = 48;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		logic [1:0]         verdict;
		logic [POS_W-1:0]   strip;
		logic [7:0]         iface;
		logic [PKTS_W-1:0]  pkts;
		logic [BYTES_W-1:0] total;
	} decap_result_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [3:0] cfg_wdata;

	l2tpd_pkt_if pkt_ch ();
	l2tpd_res_if res_ch ();

	l2tp_header_decapsulator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pkt       (pkt_ch),
		.res       (res_ch)
	);

	logic [POS_W-1:0]   hdr_pos;
	logic [7:0]         hdr_flags;
	logic [3:0]         hdr_ver;
	logic [15:0]        hdr_offset;
	logic [3:0]         want_version;
	logic [PKTS_W-1:0]  iface_pkts [MAX_IFACES_DEF];
	logic [BYTES_W-1:0] iface_bytes [MAX_IFACES_DEF];

	decap_result_t pending_results[$];
	int            mismatch_count;
	int            idle_cycles;
	bit            idle_on;
	bit            hold_req;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (!idle_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [7:0] pick_iface();
		if ($urandom_range(0, 9) < 7) begin
			return 8'($urandom_range(0, 3));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic int hdr_offset_pos(input logic [7:0] flags);
		return int'(HDR_BASE) + (flags[FLAG_L] ? 2 : 0) + (flags[FLAG_S] ? 4 : 0);
	endfunction

	function automatic byte_q_t make_packet(input logic [7:0] flags, input logic [3:0] ver,
			input logic [15:0] offset, input int total_len);
		byte_q_t    q;
		int         opos;
		logic [7:0] data;
		opos = hdr_offset_pos(flags);
		for (int i = 0; i < total_len; i++) begin
			data = 8'($urandom);
			if (i == 0) begin
				data = flags;
			end else if (i == 1) begin
				data[3:0] = ver;
			end else if (flags[FLAG_O] && i == opos) begin
				data = offset[15:8];
			end else if (flags[FLAG_O] && i == opos + 1) begin
				data = offset[7:0];
			end
			q.push_back(data);
		end
		return q;
	endfunction

	task automatic track_header_byte(input logic [7:0] data, input bit is_first,
			input bit is_last, input logic [7:0] iface);
		int unsigned   pos;
		int unsigned   len;
		int unsigned   opos;
		int unsigned   strip;
		decap_result_t r;
		pos = is_first ? 0 : hdr_pos;
		if (pos == 0) begin
			hdr_flags = data;
		end
		if (pos == 1) begin
			hdr_ver = data[3:0];
		end
		opos = hdr_offset_pos(hdr_flags);
		if (pos == opos) begin
			hdr_offset[15:8] = data;
		end
		if (pos == opos + 1) begin
			hdr_offset[7:0] = data;
		end
		len = (pos < POS_MAX) ? pos + 1 : POS_MAX;
		if (!is_last) begin
			hdr_pos = POS_W'(len);
		end else begin
			hdr_pos = '0;
			r = '{verdict: VERDICT_FAIL, strip: '0, iface: iface, pkts: '0, total: '0};
			if (len >= HDR_BASE && hdr_ver == want_version) begin
				if (hdr_flags[FLAG_T]) begin
					r.verdict = VERDICT_CTRL;
				end else begin
					strip = opos + (hdr_flags[FLAG_O] ? 2 + hdr_offset : 0);
					if (len >= strip) begin
						r.verdict = VERDICT_PASS;
						r.strip = POS_W'(strip);
						if (iface < MAX_IFACES_DEF) begin
							iface_pkts[iface] = iface_pkts[iface] + 1;
							iface_bytes[iface] = iface_bytes[iface] + strip;
							r.pkts = iface_pkts[iface];
							r.total = iface_bytes[iface];
						end
					end
				end
			end
			pending_results.push_back(r);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	task automatic send_byte(input logic [7:0] data, input bit is_first, input bit is_last,
			input logic [7:0] iface);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pkt_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pkt_ch.valid        = 1'b1;
		pkt_ch.packet_byte  = data;
		pkt_ch.first_byte   = is_first;
		pkt_ch.last_byte    = is_last;
		pkt_ch.rx_interface = iface;
		do @(posedge clk); while (!pkt_ch.ready);
		track_header_byte(data, is_first, is_last, iface);
		@(negedge clk);
	endtask

	task automatic send_packet(input byte_q_t q, input logic [7:0] iface, input bit mark_first,
			input bit mark_last);
		for (int i = 0; i < q.size(); i++) begin
			send_byte(q[i], mark_first && i == 0, mark_last && i == q.size() - 1, iface);
		end
		pkt_ch.valid = 1'b0;
	endtask

	task automatic drain();
		pkt_ch.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic set_version(input logic [3:0] ver);
		drain();
		cfg_we    = 1'b1;
		cfg_wdata = ver;
		@(negedge clk);
		cfg_we       = 1'b0;
		want_version = ver;
	endtask

	task automatic send_random_packet();
		logic [7:0]  flags;
		logic [3:0]  ver;
		logic [15:0] offset;
		int          hdr;
		int          total_len;
		flags = 8'($urandom);
		if ($urandom_range(0, 3) != 0) begin
			flags[FLAG_T] = 1'b0;
		end
		ver    = ($urandom_range(0, 9) == 0) ? 4'($urandom) : want_version;
		offset = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
		hdr    = hdr_offset_pos(flags) + (flags[FLAG_O] ? 2 + offset : 0);
		if (hdr > 40) begin
			total_len = $urandom_range(1, 40);
		end else if ($urandom_range(0, 7) == 0) begin
			total_len = $urandom_range(1, hdr);
		end else begin
			total_len = hdr + $urandom_range(0, 6);
		end
		send_packet(make_packet(flags, ver, offset, total_len), pick_iface(),
			$urandom_range(0, 19) != 0, 1'b1);
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 10);
		for (int i = 0; i < n; i++) begin
			send_byte(8'($urandom), 1'($urandom_range(0, 1)), i == n - 1, 8'($urandom));
		end
		pkt_ch.valid = 1'b0;
	endtask

	task automatic test_directed_cases();
		set_version(VER_RST);
		send_packet('{8'hFF}, 8'd255, 1'b1, 1'b1);
		send_packet(make_packet(8'h00, VER_RST, 16'h0, 5), 8'd1, 1'b0, 1'b1);
		send_packet('{8'h00, 8'h02, 8'hAA}, 8'd0, 1'b1, 1'b0);
		send_packet(make_packet(8'h00, VER_RST, 16'h0, 6), 8'd0, 1'b1, 1'b1);
		send_packet(make_packet(8'h80, VER_RST, 16'h0, 6), 8'd0, 1'b1, 1'b1);
		send_packet(make_packet(8'h00, 4'd3, 16'h0, 6), 8'd255, 1'b1, 1'b1);
	endtask

	task automatic run_random_traffic(input int n_items);
		int start;
		int r;
		start = 0;
		while (start < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				send_random_packet();
			end else if (r < 88) begin
				send_noise();
			end else begin
				send_packet(make_packet(8'($urandom), want_version,
					16'($urandom_range(0, 6)), int'($urandom_range(1, 8))),
					pick_iface(), 1'b1, 1'b0);
				send_random_packet();
			end
			start++;
		end
	endtask

	task automatic test_version_sweep();
		set_version(4'd0);
		run_random_traffic(8);
		idle_on = 1'b0;
		set_version(4'd15);
		run_random_traffic(8);
		idle_on = 1'b1;
		set_version(4'($urandom));
		run_random_traffic(8);
		set_version(VER_RST);
		run_random_traffic(8);
	endtask

	task automatic test_backpressure();
		drain();
		hold_req = 1'b1;
		repeat (10) begin
			send_packet(make_packet(8'h00, want_version, 16'h0, 6), pick_iface(), 1'b1, 1'b1);
		end
		drain();
	endtask

	task automatic test_long_packet();
		idle_on = 1'b0;
		set_version(VER_RST);
		send_packet(make_packet(8'h4A, VER_RST, 16'd30, LONG_LEN), 8'd2, 1'b1, 1'b1);
		idle_on = 1'b1;
	endtask

	always begin
		int gap;
		@(negedge clk);
		if (hold_req) begin
			res_ch.ready = 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_req = 1'b0;
		end else begin
			gap = pick_gap();
			if (gap > 0) begin
				res_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		res_ch.ready = 1'b1;
	end

	always @(posedge clk) begin
		decap_result_t e;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, interface", res_ch.out_interface, 0);
			end else begin
				e = pending_results.pop_front();
				if (res_ch.verdict !== e.verdict)
					report_mismatch("verdict", res_ch.verdict, e.verdict);
				if (res_ch.strip_length !== e.strip)
					report_mismatch("strip_length", res_ch.strip_length, e.strip);
				if (res_ch.out_interface !== e.iface)
					report_mismatch("out_interface", res_ch.out_interface, e.iface);
				if (res_ch.packet_count !== e.pkts)
					report_mismatch("packet_count", res_ch.packet_count, e.pkts);
				if (res_ch.byte_total !== e.total)
					report_mismatch("byte_total", res_ch.byte_total, e.total);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		pkt_ch.valid        = 1'b0;
		pkt_ch.packet_byte  = '0;
		pkt_ch.first_byte   = 1'b0;
		pkt_ch.last_byte    = 1'b0;
		pkt_ch.rx_interface = '0;
		res_ch.ready        = 1'b0;
		hdr_pos             = '0;
		hdr_flags           = '0;
		hdr_ver             = '0;
		hdr_offset          = '0;
		want_version        = VER_RST;
		mismatch_count      = 0;
		idle_cycles         = 0;
		idle_on             = 1'b1;
		hold_req            = 1'b0;
		for (int i = 0; i < MAX_IFACES_DEF; i++) begin
			iface_pkts[i]  = '0;
			iface_bytes[i] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_version_sweep();
		test_backpressure();
		test_long_packet();

		drain();
		repeat (8) @(negedge clk);
		if (pending_results.size() != 0) begin
			report_mismatch("results missing", 0, pending_results.size());
		end
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
